### hw/rtl/pcbp_pkg.sv
// pcbp_pkg: types, constants and codes shared by the prefix-code bit packer.
// No dependencies; imported by pcbp_front, pcbp_back and the top level.

package pcbp_pkg;

   localparam int TABLE_DEPTH_DEF  = 4096;
   localparam int MAX_CODE_LEN_DEF = 24;

   localparam int OP_W    = 2;
   localparam int IDX_W   = 12;
   localparam int SYM_W   = 16;
   localparam int NBYTE_W = 2;
   localparam int CODE_W  = 24;
   localparam int LEN_W   = 5;
   localparam int KEY_W   = 17;
   localparam int BYTE_W  = 8;
   localparam int PEND_W  = 7;
   localparam int CNT_W   = 3;
   localparam int ACC_W   = 32;
   localparam int BUF_W   = 24;

   // command queue between front and back; depth must be a power of two
   localparam int Q_DEPTH = 2;
   localparam int Q_AW    = 1;

   localparam logic [OP_W-1:0]    OP_LOAD   = 2'd0;
   localparam logic [OP_W-1:0]    OP_ENCODE = 2'd1;
   localparam logic [OP_W-1:0]    OP_FLUSH  = 2'd2;
   localparam logic [NBYTE_W-1:0] TWO_BYTES = 2'd2;

   typedef enum logic [1:0] {
      CMD_LOAD,
      CMD_ENCODE,
      CMD_FLUSH
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type      kind;
      logic [IDX_W-1:0]  index;
      logic [KEY_W-1:0]  key;
      logic [CODE_W-1:0] code;
      logic [LEN_W-1:0]  length;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } q_head_type;

   typedef struct packed {
      logic clearing;
      logic pop;
   } back_status_type;

   typedef struct packed {
      logic              valid;
      logic [KEY_W-1:0]  key;
      logic [CODE_W-1:0] code;
      logic [LEN_W-1:0]  length;
   } entry_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SEARCH,
      ST_PACK,
      ST_EMIT
   } state_type;

endpackage

### hw/rtl/pcbp_front.sv
// pcbp_front: accepts request items, classifies and normalises them, and
// queues the resulting commands for the back end. Depends on pcbp_pkg.

module pcbp_front import pcbp_pkg::*; #(
   parameter int TABLE_DEPTH  = TABLE_DEPTH_DEF,
   parameter int MAX_CODE_LEN = MAX_CODE_LEN_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [OP_W-1:0]       req_operation,
   input  logic [IDX_W-1:0]      req_entry_index,
   input  logic [SYM_W-1:0]      req_symbol_key,
   input  logic [NBYTE_W-1:0]    req_symbol_bytes,
   input  logic [CODE_W-1:0]     req_code_bits,
   input  logic [LEN_W-1:0]      req_code_length,
   input  back_status_type       status,
   output q_head_type            q_head
);

   cmd_type            cmd;
   logic               keep;
   logic               push;
   logic [LEN_W-1:0]   len_sat;
   logic [CODE_W:0]    code_mask;

   cmd_type            q_mem [Q_DEPTH];
   logic [Q_AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [Q_AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [Q_AW:0]      count_ff, count_in;

   always_comb begin
      len_sat = (32'(req_code_length) > 32'(MAX_CODE_LEN)) ?
                LEN_W'(MAX_CODE_LEN) : req_code_length;
      code_mask = ((CODE_W+1)'(1) << len_sat) - (CODE_W+1)'(1);

      cmd.index  = req_entry_index;
      cmd.length = len_sat;
      cmd.code   = req_code_bits & code_mask[CODE_W-1:0];
      if (req_symbol_bytes == TWO_BYTES) begin
         cmd.key = {1'b1, req_symbol_key};
      end else begin
         cmd.key = {{(KEY_W-BYTE_W){1'b0}}, req_symbol_key[BYTE_W-1:0]};
      end

      cmd.kind = CMD_LOAD;
      keep     = 1'b0;
      case (req_operation)
         OP_LOAD: begin
            cmd.kind = CMD_LOAD;
            keep     = 32'(req_entry_index) < 32'(TABLE_DEPTH);
         end
         OP_ENCODE: begin
            cmd.kind = CMD_ENCODE;
            keep     = 1'b1;
         end
         OP_FLUSH: begin
            cmd.kind = CMD_FLUSH;
            keep     = 1'b1;
         end
         default: begin
            keep = 1'b0;
         end
      endcase
   end

   assign req_stall = status.clearing || (count_ff == (Q_AW+1)'(Q_DEPTH));
   assign push      = req_valid && !req_stall && keep;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = status.pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (Q_AW+1)'(push) - (Q_AW+1)'(status.pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_mem[wr_ptr_ff] <= cmd;
      end
   end

   assign q_head.valid = (count_ff != '0);
   assign q_head.cmd   = q_mem[rd_ptr_ff];

endmodule

### hw/rtl/pcbp_back.sv
// pcbp_back: code table memory with clearing pass, first-match search,
// bit packing and the output register. Depends on pcbp_pkg.

module pcbp_back import pcbp_pkg::*; #(
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  q_head_type         q_head,
   output back_status_type    status,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [BYTE_W-1:0]  rsp_out_byte,
   output logic               rsp_last
);

   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam logic [AW-1:0] LAST_ADDR = AW'(TABLE_DEPTH - 1);
   localparam logic [AW:0]   LAST_SCAN = (AW+1)'(TABLE_DEPTH - 1);
   localparam logic [AW:0]   END_SCAN  = (AW+1)'(TABLE_DEPTH);

   entry_type              mem [TABLE_DEPTH];
   entry_type              mem_q_ff;

   state_type              state_ff, state_in;
   logic [AW-1:0]          clr_ff;
   logic [AW:0]            scan_ff;
   logic                   rd_pend_ff, rd_last_ff;
   logic [KEY_W-1:0]       key_ff;
   entry_type              hit_ff;
   logic [PEND_W-1:0]      pend_bits_ff;
   logic [CNT_W-1:0]       pend_cnt_ff;
   logic [BUF_W-1:0]       buf_ff;
   logic [1:0]             buf_cnt_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0]      rsp_byte_ff;
   logic                   rsp_last_ff;

   logic                   pop;
   logic                   mem_we;
   logic [AW-1:0]          mem_waddr;
   entry_type              mem_wdata;
   logic                   rsp_load;
   logic                   rd_hit;
   logic [ACC_W-1:0]       acc;
   logic [ACC_W-1:0]       aligned;
   logic [5:0]             total;
   logic [1:0]             nbytes;
   logic [BYTE_W-1:0]      pend_mask;
   logic [BYTE_W-1:0]      flush_byte;

   assign rd_hit = rd_pend_ff && mem_q_ff.valid && (mem_q_ff.key == key_ff);

   always_comb begin
      acc       = (ACC_W'(hit_ff.code)) | (ACC_W'(pend_bits_ff) << hit_ff.length);
      total     = 6'(pend_cnt_ff) + 6'(hit_ff.length);
      aligned   = acc << (6'd32 - total);
      nbytes    = total[4:3];
      pend_mask = (8'd1 << total[2:0]) - 8'd1;
      flush_byte = {1'b0, pend_bits_ff} << (4'd8 - {1'b0, pend_cnt_ff});
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == LAST_ADDR) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (q_head.valid) begin
               case (q_head.cmd.kind)
                  CMD_ENCODE: state_in = ST_SEARCH;
                  CMD_FLUSH:  state_in = (pend_cnt_ff != '0) ? ST_EMIT : ST_IDLE;
                  default:    state_in = ST_IDLE;
               endcase
            end
         end
         ST_SEARCH: begin
            if (rd_hit) begin
               state_in = ST_PACK;
            end else if (rd_pend_ff && rd_last_ff) begin
               state_in = ST_IDLE;
            end
         end
         ST_PACK: begin
            state_in = (nbytes != 2'd0) ? ST_EMIT : ST_IDLE;
         end
         ST_EMIT: begin
            if (rsp_load && buf_cnt_ff == 2'd1) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   // control outputs
   always_comb begin
      pop       = 1'b0;
      mem_we    = 1'b0;
      mem_waddr = clr_ff;
      mem_wdata = '0;
      rsp_load  = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            mem_we = 1'b1;
         end
         ST_IDLE: begin
            if (q_head.valid) begin
               pop = 1'b1;
               if (q_head.cmd.kind == CMD_LOAD) begin
                  mem_we           = 1'b1;
                  mem_waddr        = AW'(q_head.cmd.index);
                  mem_wdata.valid  = 1'b1;
                  mem_wdata.key    = q_head.cmd.key;
                  mem_wdata.code   = q_head.cmd.code;
                  mem_wdata.length = q_head.cmd.length;
               end
            end
         end
         ST_EMIT: begin
            rsp_load = !rsp_valid_ff || !rsp_stall;
         end
         default: begin
            pop = 1'b0;
         end
      endcase
   end

   assign status.clearing = (state_ff == ST_CLEAR);
   assign status.pop      = pop;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      mem_q_ff <= mem[scan_ff[AW-1:0]];
   end

   always_comb begin
      rsp_valid_in = rsp_load ? 1'b1 : (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         scan_ff      <= '0;
         rd_pend_ff   <= 1'b0;
         rd_last_ff   <= 1'b0;
         pend_bits_ff <= '0;
         pend_cnt_ff  <= '0;
         buf_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_pend_ff   <= (state_ff == ST_SEARCH) && (scan_ff < END_SCAN);
         rd_last_ff   <= (scan_ff == LAST_SCAN);
         if (state_ff == ST_CLEAR) begin
            clr_ff <= clr_ff + 1'b1;
         end
         if (pop) begin
            scan_ff <= '0;
            if (q_head.cmd.kind == CMD_FLUSH) begin
               buf_cnt_ff   <= 2'd1;
               pend_bits_ff <= '0;
               pend_cnt_ff  <= '0;
            end
         end
         if (state_ff == ST_SEARCH && scan_ff != END_SCAN) begin
            scan_ff <= scan_ff + 1'b1;
         end
         if (state_ff == ST_PACK) begin
            buf_cnt_ff   <= nbytes;
            pend_cnt_ff  <= total[2:0];
            pend_bits_ff <= PEND_W'(acc) & pend_mask[PEND_W-1:0];
         end
         if (rsp_load) begin
            buf_cnt_ff <= buf_cnt_ff - 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         key_ff <= q_head.cmd.key;
         if (q_head.cmd.kind == CMD_FLUSH) begin
            buf_ff <= {flush_byte, {(BUF_W-BYTE_W){1'b0}}};
         end
      end
      if (rd_hit) begin
         hit_ff <= mem_q_ff;
      end
      if (state_ff == ST_PACK) begin
         buf_ff <= aligned[ACC_W-1:ACC_W-BUF_W];
      end
      if (rsp_load) begin
         buf_ff      <= buf_ff << BYTE_W;
         rsp_byte_ff <= buf_ff[BUF_W-1:BUF_W-BYTE_W];
         rsp_last_ff <= (buf_cnt_ff == 2'd1);
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_byte = rsp_byte_ff;
   assign rsp_last     = rsp_last_ff;

endmodule

### hw/rtl/prefix_code_bit_packer_top.sv
// prefix_code_bit_packer_top: variable-length code encoder and byte packer.
// Instantiates pcbp_front and pcbp_back; depends on pcbp_pkg.
//
//   channel | ports                      | direction | moves
//   req     | req_valid / req_stall      | in        | load, encode or flush item
//   rsp     | rsp_valid / rsp_stall      | out       | packed byte with last flag
//
// Load: written into the table when the back end takes it. Flush: when bits pend, emits them
// zero-padded as the last byte. Encode: an issue step, then a first-match search in table
// order, one table entry compared per cycle from the registered table read, then a pack
// step and the emitted bytes. A two-entry queue lets items arrive during a search.
// After reset a clearing pass invalidates every table entry; req_stall is high meanwhile.
// A byte held by rsp_stall sits in the output register; later bytes of the item wait.

module prefix_code_bit_packer_top import pcbp_pkg::*; #(
   parameter int TABLE_DEPTH  = TABLE_DEPTH_DEF,
   parameter int MAX_CODE_LEN = MAX_CODE_LEN_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [OP_W-1:0]     req_operation,
   input  logic [IDX_W-1:0]    req_entry_index,
   input  logic [SYM_W-1:0]    req_symbol_key,
   input  logic [NBYTE_W-1:0]  req_symbol_bytes,
   input  logic [CODE_W-1:0]   req_code_bits,
   input  logic [LEN_W-1:0]    req_code_length,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [BYTE_W-1:0]   rsp_out_byte,
   output logic                rsp_last
);

   q_head_type       q_head;
   back_status_type  status;

   pcbp_front #(
      .TABLE_DEPTH  (TABLE_DEPTH),
      .MAX_CODE_LEN (MAX_CODE_LEN)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_operation    (req_operation),
      .req_entry_index  (req_entry_index),
      .req_symbol_key   (req_symbol_key),
      .req_symbol_bytes (req_symbol_bytes),
      .req_code_bits    (req_code_bits),
      .req_code_length  (req_code_length),
      .status           (status),
      .q_head           (q_head)
   );

   pcbp_back #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .q_head       (q_head),
      .status       (status),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_out_byte (rsp_out_byte),
      .rsp_last     (rsp_last)
   );

endmodule
